/* design/lru_raster_tile_cache_tags_core_macros.svh */
// Assertion macros for the raster tile cache tag store.
// Included by the top level; no other dependencies.
`ifndef LRU_RASTER_TILE_CACHE_TAGS_CORE_MACROS_SVH
`define LRU_RASTER_TILE_CACHE_TAGS_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LRTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define LRTC_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define LRTC_ASSERT(lbl, prop, msg)
`define LRTC_NEVER(lbl, cond, msg)
`endif
`endif

/* design/lrtc_pkg.sv */
// Shared types and constants for the raster tile cache tag store.
// No dependencies.
package lrtc_pkg;

  localparam int DEF_ENTRIES = 8;
  localparam int W_KEY       = 64;
  localparam int W_COORD     = 16;
  localparam int W_RECT      = 4 * W_COORD;
  localparam int W_CNT       = 32;
  localparam int W_SLOT      = 3;
  localparam int W_OP        = 2;
  localparam int W_CFG_IDX   = 2;
  localparam int W_CFG       = 15;
  localparam int W_EIU       = 4;
  localparam int W_WORD      = W_KEY + W_RECT + W_CNT;

  localparam logic [W_EIU-1:0] RST_ENTRIES    = W_EIU'(8);
  localparam logic [W_CFG-1:0] RST_MAX_WIDTH  = W_CFG'(640);
  localparam logic [W_CFG-1:0] RST_MAX_HEIGHT = W_CFG'(172);

  typedef enum logic [W_OP-1:0] {
    OP_LOOKUP = 2'd0,
    OP_STORE  = 2'd1,
    OP_INVAL  = 2'd2
  } op_e;

  typedef enum logic [W_CFG_IDX-1:0] {
    CFG_ENABLE     = 2'd0,
    CFG_ENTRIES    = 2'd1,
    CFG_MAX_WIDTH  = 2'd2,
    CFG_MAX_HEIGHT = 2'd3
  } cfg_e;

  typedef enum logic [1:0] {
    RES_FAIL,
    RES_INVAL,
    RES_HIT,
    RES_STORE
  } res_e;

  typedef struct packed {
    logic load;
    logic rd;
    logic adv;
    logic lru_upd;
    logic vict_here;
    logic wr_hit;
    logic wr_store;
    logic miss;
    logic inval;
    logic res_set;
    res_e res;
  } cmd_t;

  typedef struct packed {
    logic [W_OP-1:0] op;
    logic            enabled;
    logic            geo_ok;
    logic            match;
    logic            cur_valid;
    logic            last;
    logic            out_free;
  } sts_t;

endpackage

/* design/lrtc_ram.sv */
// Generic single-clock RAM, one write and one read port, registered read.
// No dependencies.
module lrtc_ram #(
  parameter  int Width = 8,
  parameter  int Depth = 8,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/lrtc_ctrl.sv */
// Sequencer for the tag store: dispatch, entry scan, write back, result.
// Depends on lrtc_pkg.
module lrtc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  lrtc_pkg::sts_t sts_i,
  output lrtc_pkg::cmd_t cmd_o
);
  import lrtc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISP,
    S_RD,
    S_CMP,
    S_WR,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  res_e   res_q, res_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o   = '0;
    cmd_o.res = res_q;
    state_d = state_q;
    res_d   = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISP;
        end
      end
      S_DISP: begin
        state_d = S_DONE;
        res_d   = RES_FAIL;
        if (sts_i.op == OP_INVAL) begin
          cmd_o.inval = 1'b1;
          res_d       = RES_INVAL;
        end else if (sts_i.enabled && sts_i.op == OP_LOOKUP) begin
          state_d = S_RD;
        end else if (sts_i.enabled && sts_i.op == OP_STORE && sts_i.geo_ok) begin
          state_d = S_RD;
        end
      end
      S_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_CMP;
      end
      S_CMP: begin
        if (sts_i.op == OP_LOOKUP) begin
          if (sts_i.match) begin
            state_d = S_DONE;
            if (sts_i.geo_ok) begin
              cmd_o.wr_hit    = 1'b1;
              cmd_o.vict_here = 1'b1;
              res_d           = RES_HIT;
            end
          end else if (sts_i.last) begin
            cmd_o.miss = 1'b1;
            state_d    = S_DONE;
          end else begin
            cmd_o.adv = 1'b1;
            state_d   = S_RD;
          end
        end else begin
          if (!sts_i.cur_valid) begin
            cmd_o.vict_here = 1'b1;
            state_d         = S_WR;
          end else begin
            cmd_o.lru_upd = 1'b1;
            if (sts_i.last) begin
              state_d = S_WR;
            end else begin
              cmd_o.adv = 1'b1;
              state_d   = S_RD;
            end
          end
        end
      end
      S_WR: begin
        cmd_o.wr_store = 1'b1;
        res_d          = RES_STORE;
        state_d        = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.res_set = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      res_q   <= RES_FAIL;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

endmodule

/* design/lrtc_dp.sv */
// Datapath: config registers, input word, tag RAM, valid bits, counters,
// geometry check, victim tracking and output register. Depends on lrtc_pkg, lrtc_ram.
module lrtc_dp #(
  parameter int MAX_ENTRIES = lrtc_pkg::DEF_ENTRIES
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lrtc_pkg::W_CFG_IDX-1:0]    cfg_idx_i,
  input  logic [lrtc_pkg::W_CFG-1:0]        cfg_wdata_i,
  input  logic [lrtc_pkg::W_OP-1:0]         operation_i,
  input  logic [lrtc_pkg::W_KEY-1:0]        key_tag_i,
  input  logic signed [lrtc_pkg::W_COORD-1:0] pos_x_i,
  input  logic signed [lrtc_pkg::W_COORD-1:0] pos_y_i,
  input  logic signed [lrtc_pkg::W_COORD-1:0] rect_w_i,
  input  logic signed [lrtc_pkg::W_COORD-1:0] rect_h_i,
  input  logic signed [lrtc_pkg::W_COORD-1:0] raw_stride_i,
  input  logic                              out_ready_i,
  input  lrtc_pkg::cmd_t                    cmd_i,
  output lrtc_pkg::sts_t                    sts_o,
  output logic                              out_valid_o,
  output logic                              success_o,
  output logic [lrtc_pkg::W_SLOT-1:0]       slot_o,
  output logic signed [lrtc_pkg::W_COORD-1:0] phys_x_o,
  output logic signed [lrtc_pkg::W_COORD-1:0] phys_y_o,
  output logic signed [lrtc_pkg::W_COORD-1:0] phys_w_o,
  output logic signed [lrtc_pkg::W_COORD-1:0] phys_h_o,
  output logic [lrtc_pkg::W_CNT-1:0]        hit_total_o,
  output logic [lrtc_pkg::W_CNT-1:0]        miss_total_o,
  output logic [lrtc_pkg::W_CNT-1:0]        store_total_o
);
  import lrtc_pkg::*;

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int NW = (CW > W_EIU) ? CW : W_EIU;

  // config
  logic             enable_q;
  logic [W_EIU-1:0] entries_q;
  logic [W_CFG-1:0] max_w_q, max_h_q;

  // captured word
  logic [W_OP-1:0]    op_q;
  logic [W_KEY-1:0]   key_q;
  logic [W_COORD-1:0] x_q, y_q, w_q, h_q, px_q;
  logic               geo_ok_q;

  // control state
  logic [MAX_ENTRIES-1:0] valid_q;
  logic [NW-1:0]          idx_q;
  logic [W_CNT-1:0]       use_q, hit_q, miss_q, store_q;
  logic                   out_valid_q;

  // scan payload
  logic [AW-1:0]    vict_q;
  logic [W_CNT-1:0] best_q;

  // output payload
  logic               out_succ_q;
  logic [W_SLOT-1:0]  out_slot_q;
  logic [W_COORD-1:0] out_px_q, out_py_q, out_pw_q, out_ph_q;
  logic [W_CNT-1:0]   out_hit_q, out_miss_q, out_store_q;

  logic [NW-1:0]      n_act, eiu_ext, max_n;
  logic [AW-1:0]      idx_a;
  logic [W_COORD-1:0] px_d;
  logic [W_COORD:0]   reach, stride_ext;
  logic               geo_ok_d;
  logic [W_WORD-1:0]  rdata, wdata;
  logic [W_KEY-1:0]   rd_tag;
  logic [W_RECT-1:0]  rd_rect, rect_q;
  logic [W_CNT-1:0]   rd_stamp, use_inc;
  logic [AW+W_SLOT-1:0] vict_ext;
  logic               res_ok;

  assign eiu_ext = NW'(entries_q);
  assign max_n   = NW'(MAX_ENTRIES);
  assign n_act   = (eiu_ext > max_n) ? max_n : eiu_ext;
  assign idx_a   = idx_q[AW-1:0];
  assign rect_q  = {h_q, w_q, y_q, x_q};
  assign use_inc = use_q + W_CNT'(1);

  // rotated geometry: phys_x = stride - y - h (16-bit wrap)
  assign px_d       = W_COORD'(raw_stride_i - pos_y_i - rect_h_i);
  assign reach      = {1'b0, px_d} + {1'b0, rect_h_i};
  assign stride_ext = {1'b0, raw_stride_i};
  assign geo_ok_d   = !rect_w_i[W_COORD-1] && (rect_w_i != '0)
                   && !rect_h_i[W_COORD-1] && (rect_h_i != '0)
                   && (rect_w_i[W_COORD-2:0] <= max_w_q)
                   && (rect_h_i[W_COORD-2:0] <= max_h_q)
                   && !raw_stride_i[W_COORD-1] && (raw_stride_i != '0)
                   && !px_d[W_COORD-1] && !pos_x_i[W_COORD-1]
                   && (reach <= stride_ext);

  assign wdata = {key_q, rect_q, use_inc};

  lrtc_ram #(
    .Width(W_WORD),
    .Depth(MAX_ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_hit | cmd_i.wr_store),
    .waddr_i(cmd_i.wr_hit ? idx_a : vict_q),
    .wdata_i(wdata),
    .re_i   (cmd_i.rd),
    .raddr_i(idx_a),
    .rdata_o(rdata)
  );

  assign rd_tag   = rdata[W_WORD-1 -: W_KEY];
  assign rd_rect  = rdata[W_CNT +: W_RECT];
  assign rd_stamp = rdata[W_CNT-1:0];

  assign sts_o.op        = op_q;
  assign sts_o.enabled   = enable_q && (n_act != '0);
  assign sts_o.geo_ok    = geo_ok_q;
  assign sts_o.cur_valid = valid_q[idx_a];
  assign sts_o.match     = valid_q[idx_a] && (rd_tag == key_q) && (rd_rect == rect_q);
  assign sts_o.last      = (idx_q == n_act - NW'(1));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign vict_ext = (AW + W_SLOT)'(vict_q);
  assign res_ok   = (cmd_i.res == RES_HIT) || (cmd_i.res == RES_STORE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b0;
      entries_q   <= RST_ENTRIES;
      max_w_q     <= RST_MAX_WIDTH;
      max_h_q     <= RST_MAX_HEIGHT;
      valid_q     <= '0;
      idx_q       <= '0;
      use_q       <= '0;
      hit_q       <= '0;
      miss_q      <= '0;
      store_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_e'(cfg_idx_i))
          CFG_ENABLE:     enable_q  <= cfg_wdata_i[0];
          CFG_ENTRIES:    entries_q <= cfg_wdata_i[W_EIU-1:0];
          CFG_MAX_WIDTH:  max_w_q   <= cfg_wdata_i;
          CFG_MAX_HEIGHT: max_h_q   <= cfg_wdata_i;
        endcase
      end
      if (cmd_i.load) begin
        idx_q <= '0;
      end else if (cmd_i.adv) begin
        idx_q <= idx_q + NW'(1);
      end
      if (cmd_i.inval) begin
        valid_q <= '0;
        use_q   <= '0;
      end else if (cmd_i.wr_hit || cmd_i.wr_store) begin
        use_q <= use_inc;
      end
      if (cmd_i.wr_store) begin
        valid_q[vict_q] <= 1'b1;
        store_q         <= store_q + W_CNT'(1);
      end
      if (cmd_i.wr_hit) begin
        hit_q <= hit_q + W_CNT'(1);
      end
      if (cmd_i.miss) begin
        miss_q <= miss_q + W_CNT'(1);
      end
      if (cmd_i.res_set) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= operation_i;
      key_q    <= key_tag_i;
      x_q      <= pos_x_i;
      y_q      <= pos_y_i;
      w_q      <= rect_w_i;
      h_q      <= rect_h_i;
      px_q     <= px_d;
      geo_ok_q <= geo_ok_d;
    end
    if (cmd_i.vict_here) begin
      vict_q <= idx_a;
    end else if (cmd_i.lru_upd && ((idx_q == '0) || (rd_stamp < best_q))) begin
      vict_q <= idx_a;
      best_q <= rd_stamp;
    end
    if (cmd_i.res_set) begin
      out_succ_q  <= res_ok || (cmd_i.res == RES_INVAL);
      out_slot_q  <= res_ok ? vict_ext[W_SLOT-1:0] : '0;
      out_px_q    <= res_ok ? px_q : '0;
      out_py_q    <= res_ok ? x_q : '0;
      out_pw_q    <= res_ok ? h_q : '0;
      out_ph_q    <= res_ok ? w_q : '0;
      out_hit_q   <= hit_q;
      out_miss_q  <= miss_q;
      out_store_q <= store_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign success_o     = out_succ_q;
  assign slot_o        = out_slot_q;
  assign phys_x_o      = out_px_q;
  assign phys_y_o      = out_py_q;
  assign phys_w_o      = out_pw_q;
  assign phys_h_o      = out_ph_q;
  assign hit_total_o   = out_hit_q;
  assign miss_total_o  = out_miss_q;
  assign store_total_o = out_store_q;

endmodule

/* design/lru_raster_tile_cache_tags_core.sv */
// Top level of the fully associative LRU tag store for cached text rasters.
// Depends on lrtc_pkg, lrtc_ctrl, lrtc_dp and the assertion macro header.
//
//   channel  dir  handshake              contents
//   cfg      in   cfg_we_i               register index and data, no stall
//   in       in   in_valid_i/in_ready_o  operation, key, rectangle, stride
//   out      out  out_valid_o/out_ready_i status, slot, geometry, counters
//
// One word at a time. Invalidate and words rejected at dispatch go straight from
// dispatch to the result; a lookup or a store first scans entries (at most the
// active slot count), one RAM read and one compare per entry, and a store then
// writes back. A new word is taken the cycle after the result loads, even while
// it waits on out_ready_i. Reset clears valid bits and counters.
module lru_raster_tile_cache_tags_core #(
  parameter int MAX_ENTRIES = lrtc_pkg::DEF_ENTRIES
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lrtc_pkg::W_CFG_IDX-1:0]      cfg_idx_i,
  input  logic [lrtc_pkg::W_CFG-1:0]          cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [lrtc_pkg::W_OP-1:0]           operation_i,
  input  logic [lrtc_pkg::W_KEY-1:0]          key_tag_i,
  input  logic signed [lrtc_pkg::W_COORD-1:0] pos_x_i,
  input  logic signed [lrtc_pkg::W_COORD-1:0] pos_y_i,
  input  logic signed [lrtc_pkg::W_COORD-1:0] rect_w_i,
  input  logic signed [lrtc_pkg::W_COORD-1:0] rect_h_i,
  input  logic signed [lrtc_pkg::W_COORD-1:0] raw_stride_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                success_o,
  output logic [lrtc_pkg::W_SLOT-1:0]         slot_o,
  output logic signed [lrtc_pkg::W_COORD-1:0] phys_x_o,
  output logic signed [lrtc_pkg::W_COORD-1:0] phys_y_o,
  output logic signed [lrtc_pkg::W_COORD-1:0] phys_w_o,
  output logic signed [lrtc_pkg::W_COORD-1:0] phys_h_o,
  output logic [lrtc_pkg::W_CNT-1:0]          hit_total_o,
  output logic [lrtc_pkg::W_CNT-1:0]          miss_total_o,
  output logic [lrtc_pkg::W_CNT-1:0]          store_total_o
);
  import lrtc_pkg::*;

`include "lru_raster_tile_cache_tags_core_macros.svh"

  cmd_t cmd;
  sts_t sts;

  lrtc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  lrtc_dp #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .operation_i  (operation_i),
    .key_tag_i    (key_tag_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .rect_w_i     (rect_w_i),
    .rect_h_i     (rect_h_i),
    .raw_stride_i (raw_stride_i),
    .out_ready_i  (out_ready_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .success_o    (success_o),
    .slot_o       (slot_o),
    .phys_x_o     (phys_x_o),
    .phys_y_o     (phys_y_o),
    .phys_w_o     (phys_w_o),
    .phys_h_o     (phys_h_o),
    .hit_total_o  (hit_total_o),
    .miss_total_o (miss_total_o),
    .store_total_o(store_total_o)
  );

  `LRTC_ASSERT(a_busy_after_accept, in_valid_i && in_ready_o |=> !in_ready_o, "accepted twice")
  `LRTC_NEVER(a_one_update, !$onehot0({cmd.wr_hit, cmd.wr_store, cmd.inval, cmd.miss}), "update clash")
  `LRTC_ASSERT(a_fail_zero, out_valid_o && !success_o |-> slot_o == '0 && phys_x_o == '0 && phys_h_o == '0, "failed result not zero")
  `LRTC_NEVER(a_load_idle, cmd.res_set && !sts.out_free, "result overwritten")

endmodule

/* tb/lru_raster_tile_cache_tags_core_tb.sv */
// Self-checking testbench for lru_raster_tile_cache_tags_core: directed table, then random words.
// Carries its own predictor of the LRU tag store; depends only on lrtc_pkg and the design.
module lru_raster_tile_cache_tags_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lrtc_pkg::*;

  localparam logic [W_OP-1:0] OP_RESERVED = 2'd3;
  localparam int STALL_LIMIT    = 2000;
  localparam int SQUEEZE_CYCLES = 300;

  typedef struct {
    logic [W_OP-1:0]           op;
    logic [W_KEY-1:0]          key;
    logic signed [W_COORD-1:0] pos_x;
    logic signed [W_COORD-1:0] pos_y;
    logic signed [W_COORD-1:0] rect_w;
    logic signed [W_COORD-1:0] rect_h;
    logic signed [W_COORD-1:0] raw_stride;
  } tile_req_t;

  typedef struct {
    logic                      success;
    logic [W_SLOT-1:0]         slot;
    logic signed [W_COORD-1:0] phys_x;
    logic signed [W_COORD-1:0] phys_y;
    logic signed [W_COORD-1:0] phys_w;
    logic signed [W_COORD-1:0] phys_h;
    logic [W_CNT-1:0]          hit_total;
    logic [W_CNT-1:0]          miss_total;
    logic [W_CNT-1:0]          store_total;
  } tile_resp_t;

  typedef struct {
    bit               is_cfg;
    cfg_e             cfg_idx;
    logic [W_CFG-1:0] cfg_val;
    tile_req_t        req;
    bit               typed;
    tile_resp_t       resp;
  } plan_row_t;

  typedef struct {
    bit en;
    int slots;
    int max_w;
    int max_h;
    int idle;
    int stall;
    int items;
    bit squeeze;
  } phase_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [W_CFG_IDX-1:0]      cfg_idx_i;
  logic [W_CFG-1:0]          cfg_wdata_i;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic [W_OP-1:0]           operation_i;
  logic [W_KEY-1:0]          key_tag_i;
  logic signed [W_COORD-1:0] pos_x_i;
  logic signed [W_COORD-1:0] pos_y_i;
  logic signed [W_COORD-1:0] rect_w_i;
  logic signed [W_COORD-1:0] rect_h_i;
  logic signed [W_COORD-1:0] raw_stride_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic                      success_o;
  logic [W_SLOT-1:0]         slot_o;
  logic signed [W_COORD-1:0] phys_x_o;
  logic signed [W_COORD-1:0] phys_y_o;
  logic signed [W_COORD-1:0] phys_w_o;
  logic signed [W_COORD-1:0] phys_h_o;
  logic [W_CNT-1:0]          hit_total_o;
  logic [W_CNT-1:0]          miss_total_o;
  logic [W_CNT-1:0]          store_total_o;

  lru_raster_tile_cache_tags_core #(
    .MAX_ENTRIES(DEF_ENTRIES)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .key_tag_i    (key_tag_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .rect_w_i     (rect_w_i),
    .rect_h_i     (rect_h_i),
    .raw_stride_i (raw_stride_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .success_o    (success_o),
    .slot_o       (slot_o),
    .phys_x_o     (phys_x_o),
    .phys_y_o     (phys_y_o),
    .phys_w_o     (phys_w_o),
    .phys_h_o     (phys_h_o),
    .hit_total_o  (hit_total_o),
    .miss_total_o (miss_total_o),
    .store_total_o(store_total_o)
  );

  always #5ns clk_i = ~clk_i;

  // shadow tag store
  logic [W_KEY-1:0]  tag_mem   [DEF_ENTRIES];
  logic [W_RECT-1:0] rect_mem  [DEF_ENTRIES];
  bit                valid_mem [DEF_ENTRIES];
  logic [W_CNT-1:0]  stamp_mem [DEF_ENTRIES];
  logic [W_CNT-1:0]  use_cnt   = '0;
  logic [W_CNT-1:0]  hit_cnt   = '0;
  logic [W_CNT-1:0]  miss_cnt  = '0;
  logic [W_CNT-1:0]  store_cnt = '0;
  bit                cfg_on    = 1'b0;
  logic [W_EIU-1:0]  cfg_slots = RST_ENTRIES;
  logic [W_CFG-1:0]  cfg_max_w = RST_MAX_WIDTH;
  logic [W_CFG-1:0]  cfg_max_h = RST_MAX_HEIGHT;

  tile_resp_t outcomes_due[$];
  tile_req_t  recent[$];
  int         errors        = 0;
  int         send_idle_pct = 0;
  int         stall_pct     = 0;
  bit         squeeze_out   = 1'b0;
  int         quiet_cycles  = 0;

  initial begin
    for (int i = 0; i < DEF_ENTRIES; i++) begin
      valid_mem[i] = 1'b0;
      stamp_mem[i] = '0;
    end
  end

  function automatic bit geo_fits(tile_req_t r, output logic signed [W_COORD-1:0] px_o);
    int x, y, w, h, s, px, mw, mh;
    logic signed [W_COORD-1:0] px16;
    px_o = '0;
    x = r.pos_x;
    y = r.pos_y;
    w = r.rect_w;
    h = r.rect_h;
    s = r.raw_stride;
    mw = cfg_max_w;
    mh = cfg_max_h;
    if (w <= 0 || h <= 0 || w > mw || h > mh || s <= 0) return 1'b0;
    px16 = 16'(s - y - h);
    px = px16;
    if (px < 0 || x < 0 || px + h > s) return 1'b0;
    px_o = px16;
    return 1'b1;
  endfunction

  function automatic tile_resp_t cache_op_outcome(tile_req_t r);
    tile_resp_t o;
    int n, sl, i;
    bit on, ok, found;
    logic [W_RECT-1:0] rect;
    logic signed [W_COORD-1:0] px;
    logic [W_CNT-1:0] oldest;
    o = '{default: '0};
    n = (cfg_slots > DEF_ENTRIES) ? DEF_ENTRIES : int'(cfg_slots);
    on = cfg_on && n != 0;
    ok = 1'b0;
    found = 1'b0;
    sl = 0;
    px = '0;
    rect = {r.rect_h, r.rect_w, r.pos_y, r.pos_x};
    case (r.op)
      OP_LOOKUP: begin
        if (on) begin
          for (i = 0; i < n; i++) begin
            if (!found && valid_mem[i] && tag_mem[i] == r.key && rect_mem[i] == rect) begin
              found = 1'b1;
              sl = i;
            end
          end
          if (!found) begin
            miss_cnt++;
          end else if (geo_fits(r, px)) begin
            use_cnt++;
            stamp_mem[sl] = use_cnt;
            hit_cnt++;
            ok = 1'b1;
          end
        end
      end
      OP_STORE: begin
        if (on && geo_fits(r, px)) begin
          for (i = 0; i < n; i++) begin
            if (!found && !valid_mem[i]) begin
              found = 1'b1;
              sl = i;
            end
          end
          if (!found) begin
            oldest = stamp_mem[0];
            for (i = 1; i < n; i++) begin
              if (stamp_mem[i] < oldest) begin
                oldest = stamp_mem[i];
                sl = i;
              end
            end
          end
          valid_mem[sl] = 1'b1;
          tag_mem[sl] = r.key;
          rect_mem[sl] = rect;
          use_cnt++;
          stamp_mem[sl] = use_cnt;
          store_cnt++;
          ok = 1'b1;
        end
      end
      OP_INVAL: begin
        for (i = 0; i < DEF_ENTRIES; i++) begin
          valid_mem[i] = 1'b0;
          stamp_mem[i] = '0;
        end
        use_cnt = '0;
        ok = 1'b1;
      end
      default: ;
    endcase
    o.success = ok;
    if (ok && r.op != OP_INVAL) begin
      o.slot = 3'(sl);
      o.phys_x = px;
      o.phys_y = r.pos_x;
      o.phys_w = r.rect_h;
      o.phys_h = r.rect_w;
    end
    o.hit_total = hit_cnt;
    o.miss_total = miss_cnt;
    o.store_total = store_cnt;
    return o;
  endfunction

  function automatic tile_req_t mk_req(logic [W_OP-1:0] op, logic [W_KEY-1:0] key,
                                       int x, int y, int w, int h, int s);
    tile_req_t r;
    r.op = op;
    r.key = key;
    r.pos_x = 16'(x);
    r.pos_y = 16'(y);
    r.rect_w = 16'(w);
    r.rect_h = 16'(h);
    r.raw_stride = 16'(s);
    return r;
  endfunction

  function automatic plan_row_t item_row(tile_req_t r);
    plan_row_t p;
    p.is_cfg = 1'b0;
    p.cfg_idx = CFG_ENABLE;
    p.cfg_val = '0;
    p.req = r;
    p.typed = 1'b0;
    p.resp = '{default: '0};
    return p;
  endfunction

  // failed operations and invalidate: slot and geometry are zero
  function automatic plan_row_t typed_row(tile_req_t r, bit ok, int hits, int misses, int stores);
    plan_row_t p;
    p = item_row(r);
    p.typed = 1'b1;
    p.resp.success = ok;
    p.resp.hit_total = hits;
    p.resp.miss_total = misses;
    p.resp.store_total = stores;
    return p;
  endfunction

  function automatic plan_row_t cfg_row(cfg_e idx, int val);
    plan_row_t p;
    p = item_row(mk_req(OP_LOOKUP, '0, 0, 0, 0, 0, 0));
    p.is_cfg = 1'b1;
    p.cfg_idx = idx;
    p.cfg_val = W_CFG'(val);
    return p;
  endfunction

  function automatic phase_t mk_phase(bit en, int slots, int mw, int mh, int idle, int stall,
                                      int items, bit squeeze);
    phase_t ph;
    ph.en = en;
    ph.slots = slots;
    ph.max_w = mw;
    ph.max_h = mh;
    ph.idle = idle;
    ph.stall = stall;
    ph.items = items;
    ph.squeeze = squeeze;
    return ph;
  endfunction

  // mostly stores with legal geometry and lookups of recently stored rects
  function automatic tile_req_t draw_word();
    tile_req_t r;
    int pick, mw, mh, cap, w, h, s, kb;
    pick = $urandom_range(0, 99);
    mw = cfg_max_w;
    mh = cfg_max_h;
    if (pick >= 40 && pick < 80 && recent.size() != 0) begin
      r = recent[$urandom_range(0, recent.size() - 1)];
      r.op = OP_LOOKUP;
      case ($urandom_range(0, 9))
        0: r.raw_stride = 16'($urandom);
        1: begin
          kb = $urandom_range(0, W_KEY - 1);
          r.key[kb] = ~r.key[kb];
        end
        default: ;
      endcase
      return r;
    end
    r.key = {$urandom, $urandom};
    r.pos_x = 16'($urandom);
    r.pos_y = 16'($urandom);
    r.rect_w = 16'($urandom);
    r.rect_h = 16'($urandom);
    r.raw_stride = 16'($urandom);
    if (pick < 80) begin
      r.op = OP_STORE;
      if (recent.size() != 0 && $urandom_range(0, 3) == 0)
        r.key = recent[$urandom_range(0, recent.size() - 1)].key;
      cap = (mw > 64 && $urandom_range(0, 9) != 0) ? 64 : mw;
      w = $urandom_range(1, cap);
      cap = (mh > 64 && $urandom_range(0, 9) != 0) ? 64 : mh;
      h = $urandom_range(1, cap);
      if ($urandom_range(0, 9) == 0) begin
        s = $urandom_range(h, 32767);
      end else begin
        s = h + $urandom_range(0, 200);
        if (s > 32767) s = 32767;
      end
      r.rect_w = 16'(w);
      r.rect_h = 16'(h);
      r.raw_stride = 16'(s);
      r.pos_y = 16'($urandom_range(0, s - h));
      r.pos_x = 16'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 32767)
                                                 : $urandom_range(0, 1023));
      recent.push_back(r);
      if (recent.size() > 12) void'(recent.pop_front());
    end else if (pick < 84) begin
      r.op = OP_INVAL;
    end else if (pick < 87) begin
      r.op = OP_RESERVED;
    end else begin
      r.op = 2'($urandom);
    end
    return r;
  endfunction

  task automatic offer(tile_req_t r);
    in_valid_i <= 1'b1;
    operation_i <= r.op;
    key_tag_i <= r.key;
    pos_x_i <= r.pos_x;
    pos_y_i <= r.pos_y;
    rect_w_i <= r.rect_w;
    rect_h_i <= r.rect_h;
    raw_stride_i <= r.raw_stride;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic sender_gap();
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
  endtask

  task automatic drain(int settle);
    in_valid_i <= 1'b0;
    while (outcomes_due.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_e idx, logic [W_CFG-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_ENABLE:     cfg_on = val[0];
      CFG_ENTRIES:    cfg_slots = val[W_EIU-1:0];
      CFG_MAX_WIDTH:  cfg_max_w = val;
      CFG_MAX_HEIGHT: cfg_max_h = val;
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic cmp_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      errors++;
    end
  endtask

  // result word check
  always @(posedge clk_i) begin
    tile_resp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (outcomes_due.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual success %0d slot %0d",
                 $time, success_o, slot_o);
        errors++;
      end else begin
        want = outcomes_due.pop_front();
        cmp_field("success", want.success, success_o);
        cmp_field("slot", want.slot, slot_o);
        cmp_field("phys_x", want.phys_x, phys_x_o);
        cmp_field("phys_y", want.phys_y, phys_y_o);
        cmp_field("phys_w", want.phys_w, phys_w_o);
        cmp_field("phys_h", want.phys_h, phys_h_o);
        cmp_field("hit_total", want.hit_total, hit_total_o);
        cmp_field("miss_total", want.miss_total, miss_total_o);
        cmp_field("store_total", want.store_total, store_total_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (squeeze_out) begin
        out_ready_i <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(posedge clk_i);
        squeeze_out = 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  initial begin
    plan_row_t  plan[$];
    phase_t     phases[$];
    tile_req_t  r;
    tile_resp_t want;

    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_ENABLE;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    operation_i = OP_LOOKUP;
    key_tag_i = '0;
    pos_x_i = '0;
    pos_y_i = '0;
    rect_w_i = '0;
    rect_h_i = '0;
    raw_stride_i = '0;

    // disabled after reset; unknown op; invalidate works while disabled
    plan.push_back(typed_row(mk_req(OP_STORE, 64'h0, 10, 20, 100, 50, 480), 1'b0, 0, 0, 0));
    plan.push_back(typed_row(mk_req(OP_RESERVED, '1, -32768, -32768, -32768, -32768, -32768),
                             1'b0, 0, 0, 0));
    plan.push_back(typed_row(mk_req(OP_INVAL, 64'h0, 0, 0, 0, 0, 0), 1'b1, 0, 0, 0));
    plan.push_back(cfg_row(CFG_ENABLE, 1));
    // fill every slot so no lookup ever scans an unwritten entry
    plan.push_back(item_row(mk_req(OP_STORE, 64'h0, 0, 0, 1, 1, 1)));
    plan.push_back(item_row(mk_req(OP_STORE, '1, 32767, 0, 640, 172, 172)));
    plan.push_back(item_row(mk_req(OP_STORE, 64'h8000_0000_0000_0001, 10, 20, 100, 50, 480)));
    plan.push_back(item_row(mk_req(OP_STORE, 64'h0123_4567_89AB_CDEF, 5, 5, 5, 5, 32767)));
    plan.push_back(item_row(mk_req(OP_STORE, 64'hFEDC_BA98_7654_3210, 100, 300, 200, 100, 400)));
    plan.push_back(item_row(mk_req(OP_STORE, 64'h5555_5555_5555_5555, 1, 1, 1, 1, 2)));
    plan.push_back(item_row(mk_req(OP_STORE, 64'hAAAA_AAAA_AAAA_AAAA, 7, 0, 64, 32, 32767)));
    plan.push_back(item_row(mk_req(OP_STORE, 64'h1, 3, 2, 30, 20, 100)));
    // geometry rejects, then a lookup miss and a hit
    plan.push_back(typed_row(mk_req(OP_STORE, 64'h9, -1, 0, 0, 1, 1), 1'b0, 0, 0, 8));
    plan.push_back(typed_row(mk_req(OP_STORE, 64'h9, 0, 0, 32767, -32768, -32768),
                             1'b0, 0, 0, 8));
    plan.push_back(typed_row(mk_req(OP_STORE, 64'h9, 0, -32768, 1, 1, 32767), 1'b0, 0, 0, 8));
    plan.push_back(typed_row(mk_req(OP_STORE, 64'h9, 0, 0, 1, 173, 32767), 1'b0, 0, 0, 8));
    plan.push_back(typed_row(mk_req(OP_STORE, 64'h9, 0, -1, 1, 1, 32767), 1'b0, 0, 0, 8));
    plan.push_back(typed_row(mk_req(OP_LOOKUP, 64'h1234, 10, 20, 100, 50, 480), 1'b0, 0, 1, 8));
    plan.push_back(item_row(mk_req(OP_LOOKUP, 64'h8000_0000_0000_0001, 10, 20, 100, 50, 480)));
    // hit with bad geometry
    plan.push_back(item_row(mk_req(OP_LOOKUP, 64'h8000_0000_0000_0001, 10, 20, 100, 50, 0)));
    // LRU eviction, then a duplicate key
    plan.push_back(item_row(mk_req(OP_STORE, 64'h2222_2222_2222_2222, 10, 20, 100, 50, 480)));
    plan.push_back(item_row(mk_req(OP_STORE, 64'h8000_0000_0000_0001, 10, 20, 100, 50, 480)));
    plan.push_back(cfg_row(CFG_MAX_WIDTH, 32767));
    plan.push_back(cfg_row(CFG_MAX_HEIGHT, 32767));
    plan.push_back(item_row(mk_req(OP_STORE, 64'h7777_7777_7777_7777,
                                   32767, 0, 32767, 32767, 32767)));
    plan.push_back(item_row(mk_req(OP_LOOKUP, 64'h7777_7777_7777_7777,
                                   32767, 0, 32767, 32767, 32767)));
    plan.push_back(cfg_row(CFG_ENTRIES, 15));
    plan.push_back(item_row(mk_req(OP_LOOKUP, 64'h8000_0000_0000_0001, 10, 20, 100, 50, 480)));
    plan.push_back(cfg_row(CFG_ENTRIES, 0));
    plan.push_back(item_row(mk_req(OP_LOOKUP, '1, 32767, 0, 640, 172, 172)));
    plan.push_back(item_row(mk_req(OP_INVAL, '1, -1, -1, -1, -1, -1)));

    phases.push_back(mk_phase(1'b1, 8, 640, 172, 0, 0, 250, 1'b0));
    phases.push_back(mk_phase(1'b1, 8, 640, 172, 54, 0, 250, 1'b0));
    phases.push_back(mk_phase(1'b1, 3, 64, 48, 0, 54, 250, 1'b1));
    phases.push_back(mk_phase(1'b1, 15, 32767, 32767, 25, 25, 250, 1'b0));
    phases.push_back(mk_phase(1'b1, 1, 1, 1, 0, 0, 200, 1'b0));
    phases.push_back(mk_phase(1'b0, 8, 640, 172, 25, 25, 100, 1'b0));
    phases.push_back(mk_phase(1'b1, 5, 32767, 1, 54, 0, 250, 1'b0));
    phases.push_back(mk_phase(1'b1, 8, 1, 32767, 0, 54, 250, 1'b0));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[k]) begin
      if (plan[k].is_cfg) begin
        drain(4);
        cfg_write(plan[k].cfg_idx, plan[k].cfg_val);
      end else begin
        offer(plan[k].req);
        want = cache_op_outcome(plan[k].req);
        outcomes_due.push_back(plan[k].typed ? plan[k].resp : want);
      end
    end

    foreach (phases[p]) begin
      drain(4);
      cfg_write(CFG_ENABLE, W_CFG'(phases[p].en));
      cfg_write(CFG_ENTRIES, W_CFG'(phases[p].slots));
      cfg_write(CFG_MAX_WIDTH, W_CFG'(phases[p].max_w));
      cfg_write(CFG_MAX_HEIGHT, W_CFG'(phases[p].max_h));
      send_idle_pct = phases[p].idle;
      stall_pct = phases[p].stall;
      squeeze_out = phases[p].squeeze;
      repeat (phases[p].items) begin
        r = draw_word();
        offer(r);
        outcomes_due.push_back(cache_op_outcome(r));
        sender_gap();
      end
    end

    drain(40);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+design
design/lrtc_pkg.sv
design/lrtc_ram.sv
design/lrtc_ctrl.sv
design/lrtc_dp.sv
design/lru_raster_tile_cache_tags_core.sv
tb/lru_raster_tile_cache_tags_core_tb.sv
